// ===== hdl/ttcw_pkg.sv =====
// shared constants, types and address helpers for the text terminal cell writer
`timescale 1ns / 1ps
`default_nettype none

package ttcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int CIDX_W = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int POS_W  = $clog2(CELL_COUNT + 1);

	// port field widths
	localparam int OP_W   = 1;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int CROW_W = 5;
	localparam int CCOL_W = 7;
	localparam int CPOS_W = 11;

	localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
	localparam logic [OP_W-1:0] OP_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [CIDX_W-1:0] cidx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	// logical row to physical row of the ring
	function automatic row_t phys_row(input row_t row, input row_t base);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, base};
		if (sum >= (ROW_W + 1)'(ROWS)) begin
			sum = sum - (ROW_W + 1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic addr_t cell_addr(input row_t prow, input cidx_t col);
		return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ttcw_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ttcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== hdl/text_terminal_cell_writer.sv =====
// text terminal: cursor control, ring-row screen store, scroll and cell read
// sequence: a cell write passes through ST_WRITE and an in-range read through ST_READ before ST_DONE
// raises out_valid; return, plain newline, ignored backspace or out-of-range read go straight to ST_DONE;
// a scroll first blanks all COLUMNS (80) cells of the new bottom row in ST_BLANK
// throughput: one request at a time, the next is taken once the result has left
// reset: a clearing pass blanks all 2000 cells in color 0x07; no request taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_cell_writer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ttcw_pkg::ATTR_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ttcw_pkg::OP_W-1:0]     op,
	input  wire logic [ttcw_pkg::CHAR_W-1:0]   character,
	input  wire logic [ttcw_pkg::RROW_W-1:0]   read_row,
	input  wire logic [ttcw_pkg::RCOL_W-1:0]   read_column,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ttcw_pkg::CROW_W-1:0]   cursor_row,
	output logic      [ttcw_pkg::CCOL_W-1:0]   cursor_column,
	output logic      [ttcw_pkg::CPOS_W-1:0]   cursor_position,
	output logic      [ttcw_pkg::CELL_W-1:0]   cell_data
);

	import ttcw_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_BLANK = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	addr_t             clr_cnt_q;
	cidx_t             blank_cnt_q;
	row_t              base_q;
	row_t              row_q;
	col_t              col_q;
	logic [ATTR_W-1:0] text_color_q;
	row_t              wr_row_q;
	cidx_t             wr_col_q;
	cell_t             wr_data_q;
	logic              do_write_q;
	logic              read_hit_q;
	logic              out_valid_q;
	logic [CROW_W-1:0] cursor_row_q;
	logic [CCOL_W-1:0] cursor_column_q;
	logic [CPOS_W-1:0] cursor_position_q;
	cell_t             cell_data_q;

	logic          accept;
	row_t          nx_row;
	col_t          nx_col;
	row_t          w_row;
	col_t          w_col;
	logic          scroll;
	logic          wen;
	logic [CHAR_W-1:0] w_char;
	row_t          nx_base;
	logic          read_hit;
	logic [POS_W-1:0] pos_full;

	logic  ram_we;
	addr_t ram_addr;
	cell_t ram_wdata;
	cell_t ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign accept    = in_valid && in_ready;

	assign read_hit = (int'(read_row) < ROWS) && (int'(read_column) < COLUMNS);
	assign nx_base  = (base_q == row_t'(ROWS - 1)) ? '0 : base_q + row_t'(1);
	assign pos_full = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);

	// cursor movement and the one cell a put may write
	always_comb begin
		nx_row = row_q;
		nx_col = col_q;
		w_row  = row_q;
		w_col  = col_q;
		scroll = 1'b0;
		wen    = 1'b0;
		w_char = character;
		priority if (character == CH_NEWLINE) begin
			nx_col = '0;
			if (row_q == row_t'(ROWS - 1)) begin
				scroll = 1'b1;
			end else begin
				nx_row = row_q + row_t'(1);
			end
		end else if (character == CH_RETURN) begin
			nx_col = '0;
		end else if (character == CH_BACKSPACE) begin
			w_char = CH_BLANK;
			if (row_q != '0 || col_q != '0) begin
				wen = 1'b1;
				if (col_q == '0) begin
					nx_row = row_q - row_t'(1);
					nx_col = col_t'(COLUMNS - 1);
				end else begin
					nx_col = col_q - col_t'(1);
				end
			end
			w_row = nx_row;
			w_col = nx_col;
		end else begin
			wen = 1'b1;
			// pending wrap takes a newline first
			if (col_q == col_t'(COLUMNS)) begin
				w_col = '0;
				if (row_q == row_t'(ROWS - 1)) begin
					scroll = 1'b1;
				end else begin
					w_row = row_q + row_t'(1);
				end
			end
			nx_row = w_row;
			nx_col = w_col + col_t'(1);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cell_addr(phys_row(wr_row_q, base_q), wr_col_q);
		ram_wdata = wr_data_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = RESET_CELL;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_addr  = cell_addr(phys_row(row_t'(ROWS - 1), base_q), blank_cnt_q);
				ram_wdata = {text_color_q, CH_BLANK};
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			blank_cnt_q  <= '0;
			base_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			text_color_q <= RESET_ATTR;
			do_write_q   <= 1'b0;
			read_hit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				text_color_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == addr_t'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + addr_t'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_READ) begin
							read_hit_q <= read_hit;
							state_q    <= read_hit ? ST_READ : ST_DONE;
						end else begin
							read_hit_q  <= 1'b0;
							row_q       <= nx_row;
							col_q       <= nx_col;
							do_write_q  <= wen;
							blank_cnt_q <= '0;
							if (scroll) begin
								base_q  <= nx_base;
								state_q <= ST_BLANK;
							end else begin
								state_q <= wen ? ST_WRITE : ST_DONE;
							end
						end
					end
				end
				ST_BLANK: begin
					if (blank_cnt_q == cidx_t'(COLUMNS - 1)) begin
						state_q <= do_write_q ? ST_WRITE : ST_DONE;
					end else begin
						blank_cnt_q <= blank_cnt_q + cidx_t'(1);
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (op == OP_READ) begin
				wr_row_q <= row_t'(read_row);
				wr_col_q <= cidx_t'(read_column);
			end else begin
				wr_row_q <= w_row;
				wr_col_q <= w_col[CIDX_W-1:0];
			end
			wr_data_q <= {text_color_q, w_char};
		end
		if (state_q == ST_DONE) begin
			cursor_row_q      <= CROW_W'(row_q);
			cursor_column_q   <= CCOL_W'(col_q);
			cursor_position_q <= CPOS_W'(pos_full);
			cell_data_q       <= read_hit_q ? ram_rdata : '0;
		end
	end

	ttcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign out_valid       = out_valid_q;
	assign cursor_row      = cursor_row_q;
	assign cursor_column   = cursor_column_q;
	assign cursor_position = cursor_position_q;
	assign cell_data       = cell_data_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) <= COLUMNS)
		else $error("cursor column beyond pending-wrap position");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) < ROWS) && (int'(base_q) < ROWS))
		else $error("cursor row or ring base out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while another is in progress");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule

`default_nettype wire
